>>> src/crc32c_combine_macros.svh
// Assertion macros for the CRC-32C combine RTL, used by crc32c_stage.
`ifndef CRC32C_COMBINE_MACROS_SVH
`define CRC32C_COMBINE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define CRC32C_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRC32C_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CRC32C_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CRC32C_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/crc32c_pkg.sv
// Types, constants and GF(2) operator functions for the CRC-32C combine block.
package crc32c_pkg;

  localparam int unsigned CRC_W = 32;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;

  // A 32x32 GF(2) operator: element k is the image of bit k (a column).
  typedef logic [CRC_W-1:0][CRC_W-1:0] mat_t;

  // What one pipeline stage hands to the next, besides the length.
  typedef struct packed {
    logic             valid;
    logic [CRC_W-1:0] crc;
    logic [CRC_W-1:0] second;
  } stage_t;

  // Multiply operator m by vector v over GF(2).
  function automatic logic [CRC_W-1:0] mat_apply(mat_t m, logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    r = '0;
    for (int unsigned k = 0; k < CRC_W; k++) begin
      if (v[k]) begin
        r = r ^ m[k];
      end
    end
    return r;
  endfunction

  // Product a*b: b is applied first, then a.
  function automatic mat_t mat_mul(mat_t a, mat_t b);
    mat_t d;
    for (int unsigned i = 0; i < CRC_W; i++) begin
      d[i] = mat_apply(a, b[i]);
    end
    return d;
  endfunction

  // Operator that advances a CRC through 2**k zero bytes.
  function automatic mat_t zero_op(int unsigned k);
    mat_t m;
    m = '0;
    m[0] = CRC_POLY;
    for (int unsigned i = 1; i < CRC_W; i++) begin
      m[i][i-1] = 1'b1;
    end
    // Three squarings give one byte, each further squaring doubles it.
    for (int unsigned i = 0; i < k + 3; i++) begin
      m = mat_mul(m, m);
    end
    return m;
  endfunction

  // Swap columns for rows, so each output bit is one masked parity.
  function automatic mat_t transpose(mat_t m);
    mat_t t;
    for (int unsigned j = 0; j < CRC_W; j++) begin
      for (int unsigned k = 0; k < CRC_W; k++) begin
        t[j][k] = m[k][j];
      end
    end
    return t;
  endfunction

endpackage

>>> src/crc32c_stage.sv
// One pipeline stage: applies the zero-byte operator for length bit K.
`include "crc32c_combine_macros.svh"

module crc32c_stage #(
  parameter int unsigned LENGTH_BITS = 64,
  parameter int unsigned K = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  crc32c_pkg::stage_t     up,
  input  logic [LENGTH_BITS-1:0] up_len,
  output crc32c_pkg::stage_t     dn,
  output logic [LENGTH_BITS-1:0] dn_len
);

  // Row masks of the operator for 2**K zero bytes, fixed at elaboration.
  localparam crc32c_pkg::mat_t ROWS =
    crc32c_pkg::transpose(crc32c_pkg::zero_op(K));

  crc32c_pkg::stage_t dn_r;
  logic [LENGTH_BITS-1:0] dn_len_r;
  logic [crc32c_pkg::CRC_W-1:0] crc_adv;
  logic [crc32c_pkg::CRC_W-1:0] crc_nxt;

  // Each output bit is the parity of the CRC under its row mask.
  always_comb begin
    for (int unsigned j = 0; j < crc32c_pkg::CRC_W; j++) begin
      crc_adv[j] = ^(up.crc & ROWS[j]);
    end
    crc_nxt = up_len[K] ? crc_adv : up.crc;
  end

  // Valid bit is cleared by reset; the payload moves with it and holds while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_r.valid <= 1'b0;
    end else if (adv) begin
      dn_r.valid <= up.valid;
    end
    if (adv) begin
      dn_r.crc    <= crc_nxt;
      dn_r.second <= up.second;
      dn_len_r    <= up_len;
    end
  end

  assign dn     = dn_r;
  assign dn_len = dn_len_r;

  `CRC32C_ASSERT_NXT(a_valid_moves, clk, rst_n, rst_n && adv, dn.valid == $past(up.valid), "stage valid did not follow its input")
  `CRC32C_ASSERT_NXT(a_hold_stall, clk, rst_n, rst_n && !adv, $stable(dn) && $stable(dn_len), "stage changed while stalled")
  `CRC32C_ASSERT_NXT(a_clear_bit, clk, rst_n, rst_n && adv && up.valid && !up_len[K], dn.crc == $past(up.crc), "CRC changed for a clear length bit")
  `CRC32C_ASSERT_NXT(a_side_data, clk, rst_n, rst_n && adv && up.valid, dn.second == $past(up.second) && dn_len == $past(up_len), "side data altered in stage")

endmodule

>>> src/crc32c_combine.sv
// Top level of the CRC-32C combine block: length-bit pipeline and output register.
//
// Joins two finished CRC-32C values. An item carries the CRC of a leading
// block A, the CRC of a trailing block B and the byte length of B; the result
// item carries the CRC-32C of A followed by B.
// Both channels use valid and stall. An item is taken on a rising edge where
// in_valid is high and in_stall is low; a result leaves on an edge where
// out_valid is high and out_stall is low.
// The pipeline has one stage per length bit. Stage k advances the CRC of A
// through 2**k zero bytes when bit k of the length is set, using a constant
// 32x32 GF(2) operator. The final register XORs in the CRC of B.
// An accepted item passes through every stage register, then the output register.
// Throughput: one item per cycle while no result is held by out_stall, set by the single shared advance enable.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall goes high; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits; no clearing pass.
// Only the low LENGTH_BITS bits of the length take part.

module crc32c_combine #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            in_crc_first,
  input  logic [31:0]            in_crc_second,
  input  logic [LENGTH_BITS-1:0] in_second_length,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_crc_joined
);

  crc32c_pkg::stage_t     pipe     [0:LENGTH_BITS];
  logic [LENGTH_BITS-1:0] len_pipe [0:LENGTH_BITS];
  logic                   adv;
  logic                   out_valid_r;
  logic [31:0]            out_crc_joined_r;

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Incoming item enters the first stage.
  assign pipe[0].valid  = in_valid;
  assign pipe[0].crc    = in_crc_first;
  assign pipe[0].second = in_crc_second;
  assign len_pipe[0]    = in_second_length;

  // One stage per bit of the length.
  for (genvar g = 0; g < LENGTH_BITS; g++) begin : g_stage
    crc32c_stage #(
      .LENGTH_BITS(LENGTH_BITS),
      .K          (g)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .up    (pipe[g]),
      .up_len(len_pipe[g]),
      .dn    (pipe[g+1]),
      .dn_len(len_pipe[g+1])
    );
  end

  // Output valid is control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pipe[LENGTH_BITS].valid;
    end
  end

  // Shifted CRC of A joined with the CRC of B.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_crc_joined_r <= pipe[LENGTH_BITS].crc ^ pipe[LENGTH_BITS].second;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_crc_joined = out_crc_joined_r;

endmodule
